>>> rtl/vif_pkg.sv
// ----------------------------------------------------------------------------
// vif_pkg
// Shared widths, operation and status codes, and the request record of the
// VLAN ingress filter table.
// ----------------------------------------------------------------------------
`default_nettype none

package vif_pkg;

  localparam int FUNC_W   = 3;
  localparam int VID_W    = 12;
  localparam int PORT_FW  = 5;
  localparam int TPID_W   = 16;
  localparam int STATUS_W = 2;

  localparam logic [TPID_W-1:0] TPID_RESET = 16'h8100;

  localparam logic [FUNC_W-1:0] FN_INGRESS = 3'd0;
  localparam logic [FUNC_W-1:0] FN_CREATE  = 3'd1;
  localparam logic [FUNC_W-1:0] FN_DELETE  = 3'd2;
  localparam logic [FUNC_W-1:0] FN_ATTACH  = 3'd3;
  localparam logic [FUNC_W-1:0] FN_DETACH  = 3'd4;

  localparam logic [STATUS_W-1:0] ST_OK         = 2'd0;
  localparam logic [STATUS_W-1:0] ST_EXISTS     = 2'd1;
  localparam logic [STATUS_W-1:0] ST_NOT_FOUND  = 2'd2;
  localparam logic [STATUS_W-1:0] ST_NOT_MEMBER = 2'd3;

  // Request held while its table entry is read back.
  typedef struct packed {
    logic [FUNC_W-1:0]  func;
    logic [VID_W-1:0]   vid;        // entry addressed (lookup VID for ingress)
    logic [PORT_FW-1:0] port;
    logic               attach_tagged;
    logic               own_tag;    // own-TPID tag with nonzero VID
    logic               have;       // ingress frame has a VID to look up
    logic               to_payload;
    logic               in_range;   // vid below the table depth
  } req_t;

endpackage

`default_nettype wire

>>> rtl/vif_ram.sv
// ----------------------------------------------------------------------------
// vif_ram
// Single-clock table memory: one write port, one read port, registered read.
// ----------------------------------------------------------------------------
`default_nettype none

module vif_ram #(
  parameter int DEPTH  = 4096,
  parameter int ADDR_W = 12,
  parameter int DATA_W = 65
) (
  input  wire logic              clk,
  input  wire logic              we,
  input  wire logic [ADDR_W-1:0] waddr,
  input  wire logic [DATA_W-1:0] wdata,
  input  wire logic              re,
  input  wire logic [ADDR_W-1:0] raddr,
  output logic      [DATA_W-1:0] rdata
);

  logic [DATA_W-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

`default_nettype wire

>>> rtl/vif_clear.sv
// ----------------------------------------------------------------------------
// vif_clear
// Post-reset sweep: writes every table entry once, leaving only VID 0 valid.
// ----------------------------------------------------------------------------
`default_nettype none

module vif_clear #(
  parameter int DEPTH  = 4096,
  parameter int ADDR_W = 12
) (
  input  wire logic              clk,
  input  wire logic              rst,
  output logic                   busy,
  output logic [ADDR_W-1:0]      addr,
  output logic                   valid_bit
);

  logic [ADDR_W-1:0] cnt;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b1;
      cnt  <= '0;
    end else if (busy) begin
      cnt <= cnt + 1'b1;
      if (cnt == ADDR_W'(DEPTH - 1)) begin
        busy <= 1'b0;
      end
    end
  end

  assign addr      = cnt;
  assign valid_bit = (cnt == '0);

endmodule

`default_nettype wire

>>> rtl/vlan_ingress_filter_table.sv
// ----------------------------------------------------------------------------
// vlan_ingress_filter_table
// 802.1Q-style VLAN table with ingress classification and table maintenance.
// ----------------------------------------------------------------------------
// Each request (ingress check, create, delete, attach, detach) first reads
// its table entry synchronously, then resolves the result and, for a table
// change, writes the entry back, so one request is in flight at a time and
// in_stall is high from when the request is registered until its result is
// loaded into the output register. The finished result sits in that
// register, so a new request is taken while it waits on out_stall; that
// request then holds in_stall high until the output register frees up.
// After reset the table is swept once, one entry per cycle, leaving only
// VID 0 valid; in_stall is held high for that time while vlan_tpid writes
// are still taken. A VID at or above NUM_VIDS names no VLAN; a port at or
// above NUM_PORTS is never a member.
// ----------------------------------------------------------------------------
`default_nettype none

module vlan_ingress_filter_table
  import vif_pkg::*;
#(
  parameter int NUM_PORTS = 32,
  parameter int NUM_VIDS  = 4096
) (
  input  wire logic                clk,
  input  wire logic                rst,

  input  wire logic                cfg_we,
  input  wire logic [TPID_W-1:0]   cfg_wdata,

  input  wire logic                in_valid,
  output logic                     in_stall,
  input  wire logic [FUNC_W-1:0]   func,
  input  wire logic [VID_W-1:0]    vid,
  input  wire logic [PORT_FW-1:0]  port,
  input  wire logic                attach_tagged,
  input  wire logic                tag_present,
  input  wire logic [TPID_W-1:0]   tag_tpid,
  input  wire logic [VID_W-1:0]    tag_vid,
  input  wire logic                default_valid,
  input  wire logic [VID_W-1:0]    default_vid,

  output logic                     out_valid,
  input  wire logic                out_stall,
  output logic [STATUS_W-1:0]      status,
  output logic                     accept,
  output logic [VID_W-1:0]         assigned_vid,
  output logic                     add_tag,
  output logic                     tag_to_payload
);

  localparam int ADDR_W = $clog2(NUM_VIDS);
  localparam int PORT_W = $clog2(NUM_PORTS);
  localparam int DATA_W = 2 * NUM_PORTS + 1;

  logic [TPID_W-1:0] vlan_tpid;

  always_ff @(posedge clk) begin
    if (rst) begin
      vlan_tpid <= TPID_RESET;
    end else if (cfg_we) begin
      vlan_tpid <= cfg_wdata;
    end
  end

  // Clearing sweep.
  logic              clr_busy;
  logic [ADDR_W-1:0] clr_addr;
  logic              clr_valid_bit;

  vif_clear #(
    .DEPTH  (NUM_VIDS),
    .ADDR_W (ADDR_W)
  ) u_clear (
    .clk       (clk),
    .rst       (rst),
    .busy      (clr_busy),
    .addr      (clr_addr),
    .valid_bit (clr_valid_bit)
  );

  // Classify on the way in and pick the entry to read.
  logic             in_xfer;
  logic             own_tpid;
  logic             cls_tagged;
  logic             cls_have;
  logic [VID_W-1:0] sel_vid;
  req_t             req_in;

  assign in_xfer    = in_valid && !in_stall;
  assign own_tpid   = (tag_tpid == vlan_tpid);
  assign cls_tagged = tag_present && own_tpid && (tag_vid != '0);
  assign cls_have   = cls_tagged || default_valid;

  always_comb begin
    if (func == FN_INGRESS) begin
      if (cls_tagged) begin
        sel_vid = tag_vid;
      end else if (default_valid) begin
        sel_vid = default_vid;
      end else begin
        sel_vid = '0;
      end
    end else begin
      sel_vid = vid;
    end
    req_in.func          = func;
    req_in.vid           = sel_vid;
    req_in.port          = port;
    req_in.attach_tagged = attach_tagged;
    req_in.own_tag       = cls_tagged;
    req_in.have          = cls_have;
    req_in.to_payload    = tag_present && !own_tpid;
    req_in.in_range      = ({1'b0, sel_vid} < (VID_W+1)'(NUM_VIDS));
  end

  // Request stage: entry read is in flight.
  req_t req;
  logic req_valid;
  logic out_load;

  assign out_load = req_valid && (!out_valid || !out_stall);
  assign in_stall = clr_busy || req_valid;

  always_ff @(posedge clk) begin
    if (rst) begin
      req_valid <= 1'b0;
    end else if (in_xfer) begin
      req_valid <= 1'b1;
    end else if (out_load) begin
      req_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_xfer) begin
      req <= req_in;
    end
  end

  // Table memory.
  logic              ram_we;
  logic [ADDR_W-1:0] ram_waddr;
  logic [DATA_W-1:0] ram_wdata;
  logic [DATA_W-1:0] ram_rdata;

  vif_ram #(
    .DEPTH  (NUM_VIDS),
    .ADDR_W (ADDR_W),
    .DATA_W (DATA_W)
  ) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (in_xfer),
    .raddr (sel_vid[ADDR_W-1:0]),
    .rdata (ram_rdata)
  );

  // Resolve and modify.
  logic                 ent_valid;
  logic [NUM_PORTS-1:0] ent_member;
  logic [NUM_PORTS-1:0] ent_tagged;
  logic                 exists;
  logic                 port_ok;
  logic [PORT_W-1:0]    port_idx;
  logic [NUM_PORTS-1:0] port_mask;
  logic                 is_member;

  assign ent_valid  = ram_rdata[DATA_W-1];
  assign ent_member = ram_rdata[2*NUM_PORTS-1:NUM_PORTS];
  assign ent_tagged = ram_rdata[NUM_PORTS-1:0];
  assign exists     = req.in_range && ent_valid;
  assign port_ok    = ({2'b00, req.port} < (PORT_FW+2)'(NUM_PORTS));
  assign port_idx   = PORT_W'(req.port);
  assign port_mask  = NUM_PORTS'(1) << port_idx;
  assign is_member  = port_ok && ((ent_member & port_mask) != '0);

  logic                st_we;
  logic [DATA_W-1:0]   st_wdata;
  logic [STATUS_W-1:0] r_status;
  logic                r_accept;
  logic [VID_W-1:0]    r_vid;
  logic                r_add_tag;
  logic                r_to_payload;

  always_comb begin
    st_we        = 1'b0;
    st_wdata     = ram_rdata;
    r_status     = ST_OK;
    r_accept     = 1'b0;
    r_vid        = '0;
    r_add_tag    = 1'b0;
    r_to_payload = 1'b0;
    unique case (req.func)
      FN_INGRESS: begin
        r_vid        = req.vid;
        r_to_payload = req.to_payload;
        if (!req.have || !exists) begin
          r_status = ST_NOT_FOUND;
        end else begin
          r_add_tag = !req.own_tag;
          if (is_member) begin
            r_accept = 1'b1;
          end else begin
            r_status = ST_NOT_MEMBER;
          end
        end
      end
      FN_CREATE: begin
        if (!req.in_range) begin
          r_status = ST_NOT_FOUND;
        end else if (ent_valid) begin
          r_status = ST_EXISTS;
        end else begin
          st_we    = 1'b1;
          st_wdata = {1'b1, {(2*NUM_PORTS){1'b0}}};
        end
      end
      FN_DELETE: begin
        if (!exists) begin
          r_status = ST_NOT_FOUND;
        end else begin
          st_we    = 1'b1;
          st_wdata = '0;
        end
      end
      FN_ATTACH: begin
        if (!exists) begin
          r_status = ST_NOT_FOUND;
        end else if (port_ok) begin
          st_we    = 1'b1;
          st_wdata = {1'b1, ent_member | port_mask,
                      req.attach_tagged ? (ent_tagged | port_mask) : ent_tagged};
        end
      end
      FN_DETACH: begin
        if (!exists) begin
          r_status = ST_NOT_FOUND;
        end else if (port_ok) begin
          st_we    = 1'b1;
          st_wdata = {1'b1, ent_member & ~port_mask, ent_tagged & ~port_mask};
        end
      end
      default: begin
      end
    endcase
  end

  // Sweep owns the write port until done; no request is taken meanwhile.
  always_comb begin
    if (clr_busy) begin
      ram_we    = 1'b1;
      ram_waddr = clr_addr;
      ram_wdata = {clr_valid_bit, {(2*NUM_PORTS){1'b0}}};
    end else begin
      ram_we    = out_load && st_we;
      ram_waddr = req.vid[ADDR_W-1:0];
      ram_wdata = st_wdata;
    end
  end

  // Output register.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_load) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      status         <= r_status;
      accept         <= r_accept;
      assigned_vid   <= r_vid;
      add_tag        <= r_add_tag;
      tag_to_payload <= r_to_payload;
    end
  end

endmodule

`default_nettype wire

>>> tb/sv/vif_table_check.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// vif_table_check
// Watches both channels and the TPID register port of the VLAN ingress
// filter table. It keeps its own copy of the table and predicts the verdict
// of every accepted request. It checks each result transfer against the
// oldest prediction and counts mismatches for the testbench top.
// ----------------------------------------------------------------------------

module vif_table_check
  import vif_pkg::*;
#(
  parameter int NUM_PORTS = 32,
  parameter int NUM_VIDS  = 4096
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                cfg_we,
  input  logic [TPID_W-1:0]   cfg_wdata,
  input  logic                in_valid,
  input  logic                in_stall,
  input  logic [FUNC_W-1:0]   func,
  input  logic [VID_W-1:0]    vid,
  input  logic [PORT_FW-1:0]  port,
  input  logic                attach_tagged,
  input  logic                tag_present,
  input  logic [TPID_W-1:0]   tag_tpid,
  input  logic [VID_W-1:0]    tag_vid,
  input  logic                default_valid,
  input  logic [VID_W-1:0]    default_vid,
  input  logic                out_valid,
  input  logic                out_stall,
  input  logic [STATUS_W-1:0] status,
  input  logic                accept,
  input  logic [VID_W-1:0]    assigned_vid,
  input  logic                add_tag,
  input  logic                tag_to_payload,
  output int                  pending,
  output int                  mismatch_count
);

  typedef struct packed {
    logic [STATUS_W-1:0] status;
    logic                accept;
    logic [VID_W-1:0]    vid;
    logic                add_tag;
    logic                to_payload;
  } verdict_t;

  logic [TPID_W-1:0]    own_tpid;
  logic                 vlan_live [NUM_VIDS];
  logic [NUM_PORTS-1:0] members   [NUM_VIDS];
  logic [NUM_PORTS-1:0] tag_ports [NUM_VIDS];
  verdict_t             expected_verdicts[$];
  int                   errs;

  function automatic logic vid_live(input logic [VID_W-1:0] v);
    return (int'(v) < NUM_VIDS) && vlan_live[v];
  endfunction

  // Classify a frame or apply a table operation to the local table copy.
  function automatic verdict_t classify_or_update(
      input logic [FUNC_W-1:0]  f,
      input logic [VID_W-1:0]   v,
      input logic [PORT_FW-1:0] p,
      input logic               att,
      input logic               tp,
      input logic [TPID_W-1:0]  tpid,
      input logic [VID_W-1:0]   tvid,
      input logic               dv,
      input logic [VID_W-1:0]   dvid);
    verdict_t         r;
    logic             own_tag;
    logic             have_vid;
    logic             port_ok;
    logic [VID_W-1:0] look;
    r        = '0;
    own_tag  = 1'b0;
    have_vid = 1'b0;
    look     = '0;
    port_ok  = int'(p) < NUM_PORTS;
    case (f)
      FN_INGRESS: begin
        if (tp) begin
          if (tpid != own_tpid) r.to_payload = 1'b1;
          else if (tvid != '0) own_tag = 1'b1;
        end
        if (own_tag) begin
          look     = tvid;
          have_vid = 1'b1;
        end else if (dv) begin
          look     = dvid;
          have_vid = 1'b1;
        end
        r.vid = look;
        if (!have_vid || !vid_live(look)) begin
          r.status = ST_NOT_FOUND;
        end else begin
          r.add_tag = !own_tag;
          if (port_ok && members[look][p]) r.accept = 1'b1;
          else r.status = ST_NOT_MEMBER;
        end
      end
      FN_CREATE: begin
        if (int'(v) >= NUM_VIDS) begin
          r.status = ST_NOT_FOUND;
        end else if (vlan_live[v]) begin
          r.status = ST_EXISTS;
        end else begin
          vlan_live[v] = 1'b1;
          members[v]   = '0;
          tag_ports[v] = '0;
        end
      end
      FN_DELETE: begin
        if (!vid_live(v)) begin
          r.status = ST_NOT_FOUND;
        end else begin
          vlan_live[v] = 1'b0;
          members[v]   = '0;
          tag_ports[v] = '0;
        end
      end
      FN_ATTACH: begin
        if (!vid_live(v)) begin
          r.status = ST_NOT_FOUND;
        end else if (port_ok) begin
          if (att) tag_ports[v][p] = 1'b1;
          members[v][p] = 1'b1;
        end
      end
      FN_DETACH: begin
        if (!vid_live(v)) begin
          r.status = ST_NOT_FOUND;
        end else if (port_ok) begin
          members[v][p]   = 1'b0;
          tag_ports[v][p] = 1'b0;
        end
      end
      default: ;
    endcase
    return r;
  endfunction

  initial begin
    pending        = 0;
    mismatch_count = 0;
    errs           = 0;
  end

  always @(posedge clk) begin
    verdict_t want;
    verdict_t got;
    if (rst) begin
      own_tpid = TPID_RESET;
      for (int i = 0; i < NUM_VIDS; i++) begin
        vlan_live[i] = (i == 0);
        members[i]   = '0;
        tag_ports[i] = '0;
      end
      expected_verdicts.delete();
    end else begin
      // Check the result first: it can never belong to a request taken now.
      if (out_valid && !out_stall) begin
        got = '{status, accept, assigned_vid, add_tag, tag_to_payload};
        if (expected_verdicts.size() == 0) begin
          errs++;
          if (errs <= 10)
            $display("%0t: unexpected result status=%0d accept=%0d vid=%0d add_tag=%0d tp=%0d",
                     $time, got.status, got.accept, got.vid, got.add_tag, got.to_payload);
        end else begin
          want = expected_verdicts.pop_front();
          if (got.status !== want.status || got.accept !== want.accept ||
              got.vid !== want.vid || got.add_tag !== want.add_tag ||
              got.to_payload !== want.to_payload) begin
            errs++;
            if (errs <= 10)
              $display({"%0t: mismatch expected status=%0d accept=%0d vid=%0d add_tag=%0d ",
                        "tp=%0d, got status=%0d accept=%0d vid=%0d add_tag=%0d tp=%0d"},
                       $time, want.status, want.accept, want.vid, want.add_tag,
                       want.to_payload, got.status, got.accept, got.vid, got.add_tag,
                       got.to_payload);
          end
        end
      end
      if (cfg_we) own_tpid = cfg_wdata;
      if (in_valid && !in_stall)
        expected_verdicts.push_back(classify_or_update(func, vid, port, attach_tagged,
                                                       tag_present, tag_tpid, tag_vid,
                                                       default_valid, default_vid));
    end
    pending        <= expected_verdicts.size();
    mismatch_count <= errs;
  end

endmodule

>>> tb/sv/vlan_ingress_filter_table_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// vlan_ingress_filter_table_tb
// Drives a directed set of frames and table operations, then several random
// phases under different TPID settings, with bursty requests and a changing
// result stall pattern. A separate checker predicts and compares results.
// ----------------------------------------------------------------------------

module vlan_ingress_filter_table_tb;
  import vif_pkg::*;

  typedef enum logic [1:0] {STALL_NONE, STALL_RANDOM, STALL_PERIODIC, STALL_HEAVY} stall_mode_e;

  localparam logic [VID_W-1:0] VID_POOL [8] = '{12'd0, 12'd1, 12'd2, 12'd3,
                                                12'd100, 12'd2048, 12'd4094, 12'd4095};
  localparam int PHASE_ITEMS = 280;

  logic                clk = 1'b0;
  logic                rst = 1'b1;
  logic                cfg_we = 1'b0;
  logic [TPID_W-1:0]   cfg_wdata = '0;
  logic                in_valid = 1'b0;
  logic                in_stall;
  logic [FUNC_W-1:0]   func = '0;
  logic [VID_W-1:0]    vid = '0;
  logic [PORT_FW-1:0]  port = '0;
  logic                attach_tagged = 1'b0;
  logic                tag_present = 1'b0;
  logic [TPID_W-1:0]   tag_tpid = '0;
  logic [VID_W-1:0]    tag_vid = '0;
  logic                default_valid = 1'b0;
  logic [VID_W-1:0]    default_vid = '0;
  logic                out_valid;
  logic                out_stall = 1'b0;
  logic [STATUS_W-1:0] status;
  logic                accept;
  logic [VID_W-1:0]    assigned_vid;
  logic                add_tag;
  logic                tag_to_payload;

  int                  pending;
  int                  mismatch_count;
  int                  burst_left = 0;
  logic [TPID_W-1:0]   cur_tpid = TPID_RESET;
  stall_mode_e         stall_mode = STALL_NONE;
  int                  stall_left = 0;
  logic [7:0]          cycle_cnt = '0;

  vlan_ingress_filter_table dut (
    .clk(clk), .rst(rst),
    .cfg_we(cfg_we), .cfg_wdata(cfg_wdata),
    .in_valid(in_valid), .in_stall(in_stall),
    .func(func), .vid(vid), .port(port), .attach_tagged(attach_tagged),
    .tag_present(tag_present), .tag_tpid(tag_tpid), .tag_vid(tag_vid),
    .default_valid(default_valid), .default_vid(default_vid),
    .out_valid(out_valid), .out_stall(out_stall),
    .status(status), .accept(accept), .assigned_vid(assigned_vid),
    .add_tag(add_tag), .tag_to_payload(tag_to_payload)
  );

  vif_table_check u_table_check (
    .clk(clk), .rst(rst),
    .cfg_we(cfg_we), .cfg_wdata(cfg_wdata),
    .in_valid(in_valid), .in_stall(in_stall),
    .func(func), .vid(vid), .port(port), .attach_tagged(attach_tagged),
    .tag_present(tag_present), .tag_tpid(tag_tpid), .tag_vid(tag_vid),
    .default_valid(default_valid), .default_vid(default_vid),
    .out_valid(out_valid), .out_stall(out_stall),
    .status(status), .accept(accept), .assigned_vid(assigned_vid),
    .add_tag(add_tag), .tag_to_payload(tag_to_payload),
    .pending(pending), .mismatch_count(mismatch_count)
  );

  initial begin
    forever #1 clk = ~clk;
  end

  // Result stall: switch to a randomly chosen pattern whenever the current one runs out.
  always @(posedge clk) begin
    if (stall_left == 0) begin
      stall_mode <= stall_mode_e'($urandom_range(0, 3));
      stall_left <= $urandom_range(32, 256);
    end else begin
      stall_left <= stall_left - 1;
    end
    case (stall_mode)
      STALL_NONE:     out_stall <= 1'b0;
      STALL_RANDOM:   out_stall <= ($urandom_range(0, 2) == 0);
      STALL_PERIODIC: out_stall <= (cycle_cnt[2:0] < 3'd3);
      default:        out_stall <= ($urandom_range(0, 3) != 0);
    endcase
    cycle_cnt <= cycle_cnt + 8'd1;
  end

  // Present one request and hold it until the transfer happens.
  task automatic send_req(input logic [FUNC_W-1:0] f, input logic [VID_W-1:0] v,
                          input logic [PORT_FW-1:0] p, input logic att,
                          input logic tp, input logic [TPID_W-1:0] tpid,
                          input logic [VID_W-1:0] tvid, input logic dv,
                          input logic [VID_W-1:0] dvid);
    int gap;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 40);
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
      if (gap > 0) begin
        in_valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
    burst_left--;
    in_valid      <= 1'b1;
    func          <= f;
    vid           <= v;
    port          <= p;
    attach_tagged <= att;
    tag_present   <= tp;
    tag_tpid      <= tpid;
    tag_vid       <= tvid;
    default_valid <= dv;
    default_vid   <= dvid;
    @(posedge clk);
    while (in_stall) @(posedge clk);
  endtask

  function automatic logic [VID_W-1:0] pick_vid();
    if ($urandom_range(0, 4) != 0) return VID_POOL[$urandom_range(0, 7)];
    return VID_W'($urandom_range(0, 4095));
  endfunction

  // Half frames, the rest mostly table traffic, on a few VLANs and ports so frames get admitted.
  task automatic send_random_req();
    logic [FUNC_W-1:0]  f;
    logic [PORT_FW-1:0] p;
    logic [TPID_W-1:0]  tpid;
    logic [VID_W-1:0]   tvid;
    int                 r;
    r = $urandom_range(0, 99);
    if (r < 50)      f = FN_INGRESS;
    else if (r < 60) f = FN_CREATE;
    else if (r < 66) f = FN_DELETE;
    else if (r < 86) f = FN_ATTACH;
    else if (r < 96) f = FN_DETACH;
    else             f = FN_DETACH + FUNC_W'($urandom_range(1, 3));
    p    = ($urandom_range(0, 9) < 6) ? PORT_FW'($urandom_range(0, 3))
                                      : PORT_FW'($urandom_range(0, 31));
    tpid = ($urandom_range(0, 9) < 7) ? cur_tpid : TPID_W'($urandom_range(0, 65535));
    tvid = ($urandom_range(0, 9) == 0) ? '0 : pick_vid();
    send_req(f, pick_vid(), p, 1'($urandom_range(0, 1)), ($urandom_range(0, 3) != 0),
             tpid, tvid, ($urandom_range(0, 4) != 0), pick_vid());
  endtask

  task automatic wait_drained();
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_tpid(input logic [TPID_W-1:0] value);
    wait_drained();
    cfg_we    <= 1'b1;
    cfg_wdata <= value;
    @(posedge clk);
    cfg_we   <= 1'b0;
    cur_tpid = value;
  endtask

  task automatic run_phase(input logic [TPID_W-1:0] value);
    write_tpid(value);
    repeat (PHASE_ITEMS) send_random_req();
  endtask

  initial begin
    #1_000_000;
    $display("FAIL");
    $finish;
  end

  initial begin
    repeat (2) @(posedge clk);
    rst <= 1'b0;

    // Directed part under the reset TPID.
    // Untagged frame into VID 0 before any port is a member.
    send_req(FN_INGRESS, 12'd0, 5'd0, 1'b0, 1'b0, 16'h0000, 12'd0, 1'b1, 12'd0);
    send_req(FN_ATTACH, 12'd0, 5'd0, 1'b1, 1'b0, 16'h0000, 12'd0, 1'b0, 12'd0);
    send_req(FN_INGRESS, 12'd0, 5'd0, 1'b0, 1'b0, 16'hFFFF, 12'd4095, 1'b1, 12'd0);
    send_req(FN_CREATE, 12'd0, 5'd0, 1'b0, 1'b0, 16'h0000, 12'd0, 1'b0, 12'd0);
    send_req(FN_CREATE, 12'd4095, 5'd31, 1'b1, 1'b1, 16'hFFFF, 12'd4095, 1'b1, 12'd4095);
    send_req(FN_ATTACH, 12'd4095, 5'd31, 1'b0, 1'b0, 16'h0000, 12'd0, 1'b0, 12'd0);
    // Own tag, member and non-member port.
    send_req(FN_INGRESS, 12'd0, 5'd31, 1'b0, 1'b1, TPID_RESET, 12'd4095, 1'b0, 12'd0);
    send_req(FN_INGRESS, 12'd0, 5'd0, 1'b0, 1'b1, TPID_RESET, 12'd4095, 1'b1, 12'd0);
    // Priority tag falls back to the default VID.
    send_req(FN_INGRESS, 12'd0, 5'd31, 1'b0, 1'b1, TPID_RESET, 12'd0, 1'b1, 12'd4095);
    // Foreign tag: pushed to payload, then handled as untagged.
    send_req(FN_INGRESS, 12'd0, 5'd0, 1'b0, 1'b1, 16'hFFFF, 12'd4095, 1'b1, 12'd0);
    send_req(FN_INGRESS, 12'd0, 5'd0, 1'b0, 1'b1, 16'h0000, 12'd4095, 1'b0, 12'd4095);
    // Tag into a VLAN that does not exist.
    send_req(FN_INGRESS, 12'd0, 5'd0, 1'b0, 1'b1, TPID_RESET, 12'd5, 1'b1, 12'd0);
    send_req(FN_DELETE, 12'd5, 5'd0, 1'b0, 1'b0, 16'h0000, 12'd0, 1'b0, 12'd0);
    send_req(FN_ATTACH, 12'd5, 5'd0, 1'b1, 1'b0, 16'h0000, 12'd0, 1'b0, 12'd0);
    send_req(FN_DETACH, 12'd5, 5'd0, 1'b0, 1'b0, 16'h0000, 12'd0, 1'b0, 12'd0);
    send_req(FN_DETACH, 12'd4095, 5'd31, 1'b0, 1'b0, 16'h0000, 12'd0, 1'b0, 12'd0);
    send_req(FN_INGRESS, 12'd0, 5'd31, 1'b0, 1'b1, TPID_RESET, 12'd4095, 1'b0, 12'd0);
    send_req(FN_DELETE, 12'd4095, 5'd0, 1'b0, 1'b0, 16'h0000, 12'd0, 1'b0, 12'd0);
    send_req(FN_INGRESS, 12'd0, 5'd31, 1'b0, 1'b1, TPID_RESET, 12'd4095, 1'b0, 12'd0);
    // Unused function codes with every field at its top value.
    send_req(FN_DETACH + 3'd1, 12'd4095, 5'd31, 1'b1, 1'b1, 16'hFFFF, 12'd4095, 1'b1, 12'd4095);
    send_req(FN_DETACH + 3'd2, 12'd4095, 5'd31, 1'b1, 1'b1, 16'hFFFF, 12'd4095, 1'b1, 12'd4095);
    send_req(FN_DETACH + 3'd3, 12'd4095, 5'd31, 1'b1, 1'b1, 16'hFFFF, 12'd4095, 1'b1, 12'd4095);
    // Recreate starts with empty port maps.
    send_req(FN_CREATE, 12'd4095, 5'd0, 1'b0, 1'b0, 16'h0000, 12'd0, 1'b0, 12'd0);
    send_req(FN_INGRESS, 12'd0, 5'd31, 1'b0, 1'b1, TPID_RESET, 12'd4095, 1'b0, 12'd0);
    send_req(FN_DELETE, 12'd0, 5'd0, 1'b0, 1'b0, 16'h0000, 12'd0, 1'b0, 12'd0);
    send_req(FN_INGRESS, 12'd0, 5'd0, 1'b0, 1'b0, 16'h0000, 12'd0, 1'b1, 12'd0);

    run_phase(16'h88A8);
    run_phase(16'h0000);
    run_phase(16'hFFFF);
    run_phase(TPID_W'($urandom_range(0, 65535)));
    run_phase(TPID_RESET);

    wait_drained();
    repeat (10) @(posedge clk);
    if (mismatch_count == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule

>>> filelist.f
rtl/vif_pkg.sv
rtl/vif_ram.sv
rtl/vif_clear.sv
rtl/vlan_ingress_filter_table.sv
tb/sv/vif_table_check.sv
tb/sv/vlan_ingress_filter_table_tb.sv
